>>> hdl/fully_assoc_lru_cache_assert.svh
// Assertion macros shared by the cache checker
`ifndef FULLY_ASSOC_LRU_CACHE_ASSERT_SVH
`define FULLY_ASSOC_LRU_CACHE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define FALC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define FALC_ASSERT(lbl, prop, msg) `FALC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/falc_pkg.sv
// Types and constants shared by the fully associative LRU cache modules
`default_nettype none

package falc_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LINE_WORDS = 4;
  localparam int unsigned WORD_W     = 2;
  localparam int unsigned TAG_W      = ADDR_W - WORD_W;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 96;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_DRAIN,
    ST_ACCESS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic lookup;
    logic fill_rd;
    logic access;
    logic load_out;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic clr_done;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/falc_ctrl.sv
// Sequencer for lookup, line fill, access and result hand-off
`default_nettype none

module falc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire falc_pkg::op_e     op_i,
  input  wire falc_pkg::status_t status_i,
  output logic                   s_tready_o,
  output falc_pkg::cmd_t         cmd_o
);

  import falc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (op_i == OP_READ || op_i == OP_WRITE) state_d = ST_LOOKUP;
          else                                      state_d = ST_ACCESS;
        end
      end
      ST_LOOKUP: begin
        if (status_i.hit) state_d = ST_ACCESS;
        else              state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.fill_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_ACCESS;
      ST_ACCESS: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready_o       = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.take       = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.lookup     = (state_q == ST_LOOKUP);
    cmd_o.fill_rd    = (state_q == ST_FILL);
    cmd_o.access     = (state_q == ST_ACCESS);
    cmd_o.load_out   = (state_q == ST_DONE) && status_i.out_free;
    cmd_o.clr_wr     = (state_q == ST_CLEAR);
  end

endmodule

`default_nettype wire

>>> hdl/falc_dpath.sv
// Tags, recency ranks, line store, backing memory, counters and result register
`default_nettype none

module falc_dpath #(
  parameter int unsigned NUM_LINES = 4,
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire falc_pkg::cmd_t                   cmd_i,
  output falc_pkg::status_t                     status_o,
  input  wire logic [falc_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  wire logic [falc_pkg::OP_W-1:0]        s_tuser_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  output logic [falc_pkg::M_TDATA_W-1:0]        m_tdata_o,
  output logic                                  m_tuser_o
);

  import falc_pkg::*;

  localparam int unsigned LINE_IDX_W = $clog2(NUM_LINES);
  localparam int unsigned RANK_W     = LINE_IDX_W;
  localparam int unsigned LMEM_DEPTH = NUM_LINES * LINE_WORDS;
  localparam int unsigned LMEM_AW    = LINE_IDX_W + WORD_W;
  localparam int unsigned MEM_AW     = $clog2(MEM_WORDS);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_LINES - 1);

  // Reduce a word address modulo the backing memory size; quotient stays below 16
  function automatic logic [MEM_AW-1:0] mem_idx(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = a;
    for (int k = 3; k >= 0; k--) begin
      if (32'(r) >= (MEM_WORDS << k)) r = r - ADDR_W'(MEM_WORDS << k);
    end
    return MEM_AW'(r);
  endfunction

  // Item registers
  op_e                op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  wdata_q;

  // Line directory
  logic [TAG_W-1:0]      tag_q  [NUM_LINES];
  logic [NUM_LINES-1:0]  valid_q;
  logic [RANK_W-1:0]     rank_q [NUM_LINES];
  logic [RANK_W-1:0]     rank_nxt [NUM_LINES];

  logic [LINE_IDX_W-1:0] line_q;
  logic                  hit_q;
  logic [CNT_W-1:0]      hit_cnt_q;
  logic [CNT_W-1:0]      miss_cnt_q;

  // Fill sequencing
  logic [WORD_W-1:0]     fill_cnt_q;
  logic                  rd_pend_q;
  logic [WORD_W-1:0]     rd_word_q;

  // Clearing pass
  logic [MEM_AW-1:0]     clr_cnt_q;

  // Memories
  logic [DATA_W-1:0]     bmem [MEM_WORDS];
  logic [DATA_W-1:0]     mem_rdata_q;
  logic [DATA_W-1:0]     lmem [LMEM_DEPTH];
  logic [DATA_W-1:0]     lmem_rdata_q;

  // Result register
  logic                  m_valid_q;
  logic [DATA_W-1:0]     out_rdata_q;
  logic                  out_hit_q;
  logic [CNT_W-1:0]      out_hcnt_q;
  logic [CNT_W-1:0]      out_mcnt_q;

  logic [TAG_W-1:0]      tag;
  logic [WORD_W-1:0]     sel;
  logic [NUM_LINES-1:0]  match;
  logic                  hit_any;
  logic [LINE_IDX_W-1:0] hit_line;
  logic                  free_any;
  logic [LINE_IDX_W-1:0] free_line;
  logic [LINE_IDX_W-1:0] lru_line;
  logic [LINE_IDX_W-1:0] target;
  logic                  was_valid;
  logic [RANK_W-1:0]     old_rank;

  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_waddr;
  logic [DATA_W-1:0]     mem_wdata;
  logic [MEM_AW-1:0]     mem_raddr;
  logic                  lmem_we;
  logic [LMEM_AW-1:0]    lmem_waddr;
  logic [DATA_W-1:0]     lmem_wdata;
  logic                  lmem_re;
  logic                  is_read;
  logic                  is_write;

  assign tag      = addr_q[ADDR_W-1:WORD_W];
  assign sel      = addr_q[WORD_W-1:0];
  assign is_read  = (op_q == OP_READ);
  assign is_write = (op_q == OP_WRITE);

  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      match[k] = valid_q[k] && (tag_q[k] == tag);
    end
  end

  // Hit: lowest matching line. Fill: highest invalid line, else the line ranked last.
  always_comb begin
    hit_any   = 1'b0;
    hit_line  = '0;
    free_any  = 1'b0;
    free_line = '0;
    lru_line  = '0;
    for (int k = NUM_LINES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_any  = 1'b1;
        hit_line = LINE_IDX_W'(k);
      end
    end
    for (int k = 0; k < NUM_LINES; k++) begin
      if (!valid_q[k]) begin
        free_any  = 1'b1;
        free_line = LINE_IDX_W'(k);
      end
      if (valid_q[k] && rank_q[k] == RANK_MAX) lru_line = LINE_IDX_W'(k);
    end
    if (hit_any)       target = hit_line;
    else if (free_any) target = free_line;
    else               target = lru_line;
    was_valid = hit_any || !free_any;
    old_rank  = rank_q[target];
  end

  // Touched line goes to rank 0; valid lines ranked ahead of it age by one
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      if (LINE_IDX_W'(k) == target) begin
        rank_nxt[k] = '0;
      end else if (valid_q[k] && (!was_valid || rank_q[k] < old_rank)) begin
        rank_nxt[k] = rank_q[k] + RANK_W'(1);
      end else begin
        rank_nxt[k] = rank_q[k];
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= op_e'(s_tuser_i);
      addr_q  <= s_tdata_i[ADDR_W-1:0];
      wdata_q <= s_tdata_i[ADDR_W +: DATA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      hit_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      hit_q <= hit_any;
    end
    if (cmd_i.lookup) begin
      line_q         <= target;
      tag_q[target]  <= tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      for (int k = 0; k < NUM_LINES; k++) begin
        rank_q[k] <= '0;
      end
    end else if (cmd_i.lookup) begin
      valid_q[target] <= 1'b1;
      for (int k = 0; k < NUM_LINES; k++) begin
        rank_q[k] <= rank_nxt[k];
      end
      if (hit_any) hit_cnt_q  <= hit_cnt_q + CNT_W'(1);
      else         miss_cnt_q <= miss_cnt_q + CNT_W'(1);
    end
  end

  // Fill word counter, pending line write and clearing-pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
      rd_pend_q  <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      rd_pend_q <= cmd_i.fill_rd;
      if (cmd_i.fill_rd) fill_cnt_q <= fill_cnt_q + WORD_W'(1);
      if (cmd_i.clr_wr)  clr_cnt_q  <= clr_cnt_q + MEM_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= fill_cnt_q;
  end

  // Backing memory: one write port, one registered read port
  assign mem_we    = cmd_i.clr_wr || (cmd_i.access && (is_write || op_q == OP_PRELOAD));
  assign mem_waddr = cmd_i.clr_wr ? clr_cnt_q : mem_idx(addr_q);
  assign mem_wdata = cmd_i.clr_wr ? '0 : wdata_q;
  assign mem_raddr = mem_idx({tag, fill_cnt_q});

  always_ff @(posedge clk_i) begin
    if (mem_we) bmem[mem_waddr] <= mem_wdata;
    if (cmd_i.fill_rd) mem_rdata_q <= bmem[mem_raddr];
  end

  // Line store: each fill word is written in the cycle after its backing-memory read
  assign lmem_we    = rd_pend_q || (cmd_i.access && is_write);
  assign lmem_waddr = rd_pend_q ? {line_q, rd_word_q} : {line_q, sel};
  assign lmem_wdata = rd_pend_q ? mem_rdata_q : wdata_q;
  assign lmem_re    = cmd_i.access && is_read;

  always_ff @(posedge clk_i) begin
    if (lmem_we) lmem[lmem_waddr] <= lmem_wdata;
    if (lmem_re) lmem_rdata_q <= lmem[{line_q, sel}];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rdata_q <= is_read ? lmem_rdata_q : '0;
      out_hit_q   <= hit_q;
      out_hcnt_q  <= hit_cnt_q;
      out_mcnt_q  <= miss_cnt_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {out_mcnt_q, out_hcnt_q, out_rdata_q};
  assign m_tuser_o  = out_hit_q;

  assign status_o.hit       = hit_any;
  assign status_o.clr_done  = (clr_cnt_q == MEM_AW'(MEM_WORDS - 1));
  assign status_o.fill_last = (fill_cnt_q == WORD_W'(LINE_WORDS - 1));
  assign status_o.out_free  = !m_valid_q || m_tready_i;

endmodule

`default_nettype wire

>>> hdl/fully_assoc_lru_cache.sv
// Fully associative LRU write-through cache: top level
//
// Input stream: one item per read, write, preload or no-op. tuser carries the opcode
// (read, write, preload, no-op), tdata the word address and the write word.
// Output stream: exactly one result item per input item, in order: the word
// read (zero unless a read), a hit flag in tuser, and the hit and miss counts
// after the access.
//
// One item is in work at a time. A read or write hit goes through lookup, access
// and hand-off; a miss adds four backing-memory reads through its single port and
// a step to land the last fill word between lookup and access. A preload or no-op
// goes straight to the access and then the hand-off.
// After reset the backing memory is swept to zero, one word a cycle, covering all
// MEM_WORDS words (4096 by default); s_axis_tready stays low during the sweep.
// The result waits in an output register while the receiver stalls; the next
// item is taken meanwhile and holds in its last step until that register frees.
`default_nettype none

module fully_assoc_lru_cache #(
  parameter int unsigned NUM_LINES = 4,
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [11:0] address, [43:12] write_data, [47:44] zero
  input  wire logic [falc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  wire logic [falc_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [31:0] read_data, [63:32] hit_count, [95:64] miss_count
  output logic [falc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [0] was_hit
  output logic                                  m_axis_tuser
);

  import falc_pkg::*;

  cmd_t    cmd;
  status_t status;

  falc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .op_i       (op_e'(s_axis_tuser)),
    .status_i   (status),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  falc_dpath #(
    .NUM_LINES (NUM_LINES),
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hdl/falc_checker.sv
// Port-level checker for the cache, bound to the top level
`default_nettype none

`include "fully_assoc_lru_cache_assert.svh"

module falc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [falc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Stalled result holds
  `FALC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // One item in work at a time
  `FALC_ASSERT(a_one_item, (in_acc |=> !s_axis_tready), "item accepted while busy")

  // No result appears on the cycle right after an item is taken
  `FALC_ASSERT(a_no_early_result, (in_acc |=> !$rose(m_axis_tvalid)), "result too early")

  // Clearing pass keeps input closed and output empty when reset lifts
  `FALC_ASSERT(a_clear_after_reset, ($rose(rst_ni) |-> !s_axis_tready && !m_axis_tvalid), "not clearing after reset")

endmodule

bind fully_assoc_lru_cache falc_checker u_falc_checker (.*);

`default_nettype wire

>>> bench/tb_fully_assoc_lru_cache.sv
// Self-checking testbench for the fully associative LRU write-through cache
`timescale 1ns / 100ps

module tb_fully_assoc_lru_cache;
  import falc_pkg::*;

  localparam int unsigned CACHE_LINES  = 4;
  localparam int unsigned MEM_DEPTH    = 4096;
  localparam int unsigned PHASE_ITEMS  = 527;
  localparam int unsigned HOT_TAGS     = 6;
  localparam int unsigned REPORT_LIMIT = 40;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              was_hit;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } access_result_t;

  // Mirror of the cache contents, LRU ranks, backing memory and counters.
  class lru_cache_mirror;
    bit [DATA_W-1:0] words [CACHE_LINES][LINE_WORDS];
    bit [TAG_W-1:0]  tags [CACHE_LINES];
    bit              valid [CACHE_LINES];
    int unsigned     rank [CACHE_LINES];
    bit [DATA_W-1:0] backing [MEM_DEPTH];
    bit [CNT_W-1:0]  hits;
    bit [CNT_W-1:0]  misses;
    access_result_t  pending_results [$];
    int unsigned     mismatches;

    // A line that was invalid ranks below every valid line.
    function void promote(int unsigned ln, bit was_valid);
      int unsigned old_rank;
      old_rank = was_valid ? rank[ln] : CACHE_LINES;
      for (int unsigned k = 0; k < CACHE_LINES; k++) begin
        if (k != ln && valid[k] && rank[k] < old_rank) rank[k]++;
      end
      rank[ln]  = 0;
      valid[ln] = 1'b1;
    endfunction

    function int unsigned lookup_or_fill(logic [ADDR_W-1:0] addr, output bit hit);
      bit [TAG_W-1:0] tag;
      bit             have_free;
      int unsigned    victim;
      tag       = addr[ADDR_W-1:WORD_W];
      have_free = 1'b0;
      victim    = 0;
      for (int unsigned k = 0; k < CACHE_LINES; k++) begin
        if (valid[k] && tags[k] == tag) begin
          hit = 1'b1;
          hits++;
          promote(k, 1'b1);
          return k;
        end
        if (!valid[k]) begin
          have_free = 1'b1;
          victim    = k;
        end
      end
      hit = 1'b0;
      misses++;
      // Oldest line goes; lowest index wins a tie.
      if (!have_free) begin
        for (int unsigned k = 1; k < CACHE_LINES; k++) begin
          if (rank[k] > rank[victim]) victim = k;
        end
      end
      for (int unsigned w = 0; w < LINE_WORDS; w++) begin
        words[victim][w] = backing[{tag, w[WORD_W-1:0]}];
      end
      tags[victim] = tag;
      promote(victim, !have_free);
      return victim;
    endfunction

    function void note_access(op_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      access_result_t res;
      int unsigned    ln;
      bit             hit;
      res.read_data = '0;
      hit           = 1'b0;
      case (op)
        OP_READ: begin
          ln            = lookup_or_fill(addr, hit);
          res.read_data = words[ln][addr[WORD_W-1:0]];
        end
        OP_WRITE: begin
          ln                           = lookup_or_fill(addr, hit);
          words[ln][addr[WORD_W-1:0]] = data;
          backing[addr]                = data;
        end
        OP_PRELOAD: backing[addr] = data;
        default: ;
      endcase
      res.was_hit    = hit;
      res.hit_count  = hits;
      res.miss_count = misses;
      pending_results.push_back(res);
    endfunction

    function void compare(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
      access_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                   $time, tdata, tuser);
        return;
      end
      want = pending_results.pop_front();
      compare("read_data", want.read_data, tdata[31:0]);
      compare("was_hit", DATA_W'(want.was_hit), DATA_W'(tuser));
      compare("hit_count", want.hit_count, tdata[63:32]);
      compare("miss_count", want.miss_count, tdata[95:64]);
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  int unsigned     src_idle_pct   = 13;
  int unsigned     sink_stall_pct = 86;
  lru_cache_mirror mirror;

  fully_assoc_lru_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check results at the edge they are taken, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Call at a rising edge; returns at the edge the item is taken.
  task automatic send_item(op_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W-DATA_W-ADDR_W){1'b0}}, data, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.note_access(op, addr, data);
  endtask

  // Most accesses go to a few hot lines so that hits and evictions are frequent.
  task automatic send_random(int unsigned count);
    logic [TAG_W-1:0]  hot_tags [HOT_TAGS];
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int unsigned       pick;
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom);
    repeat (count) begin
      pick = $urandom_range(99);
      op   = pick < 45 ? OP_READ : pick < 75 ? OP_WRITE : pick < 95 ? OP_PRELOAD : OP_NOP;
      if ($urandom_range(9) < 7) addr = {hot_tags[$urandom_range(HOT_TAGS-1)], WORD_W'($urandom)};
      else addr = ADDR_W'($urandom);
      case ($urandom_range(15))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      send_item(op, addr, data);
    end
  endtask

  initial begin
    mirror = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_READ,    12'h000, 32'h0000_0000);  // cold miss fills the top line
    send_item(OP_PRELOAD, 12'hFFF, 32'hFFFF_FFFF);
    send_item(OP_READ,    12'hFFF, 32'h0000_0000);  // fill picks up the preloaded word
    send_item(OP_WRITE,   12'h001, 32'hFFFF_FFFF);  // write hit
    send_item(OP_READ,    12'h001, 32'h0000_0000);
    send_item(OP_PRELOAD, 12'h002, 32'h1234_5678);  // cached copy goes stale
    send_item(OP_READ,    12'h002, 32'h0000_0000);
    send_item(OP_NOP,     12'hABC, 32'hDEAD_BEEF);
    send_item(OP_WRITE,   12'h800, 32'h0000_0000);  // write miss allocates
    send_item(OP_READ,    12'h404, 32'h0000_0000);  // last free line
    send_item(OP_READ,    12'hFFC, 32'h0000_0000);
    send_item(OP_READ,    12'h010, 32'h0000_0000);  // full: evict the oldest
    send_item(OP_READ,    12'h000, 32'h0000_0000);
    send_item(OP_WRITE,   12'h802, 32'h5A5A_A5A5);
    send_item(OP_READ,    12'h3F3, 32'h0000_0000);
    send_item(OP_READ,    12'h002, 32'h0000_0000);  // hit on the line refetched after its eviction
    send_item(OP_NOP,     12'h000, 32'h0000_0000);
    send_item(OP_PRELOAD, 12'h000, 32'h0000_0000);
    send_item(OP_READ,    12'h801, 32'h0000_0000);
    send_item(OP_WRITE,   12'hFFF, 32'h0000_0000);

    send_random(PHASE_ITEMS);
    src_idle_pct   = 86;
    sink_stall_pct = 13;
    send_random(PHASE_ITEMS);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random(PHASE_ITEMS);
    s_axis_tvalid <= 1'b0;

    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("** fully_assoc_lru_cache: PASSED **");
    end else begin
      $display("** fully_assoc_lru_cache: FAILED **");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("** fully_assoc_lru_cache: FAILED **");
    $finish;
  end

endmodule
